// ----- design/pbfs_pkg.sv -----
// ----------------------------------------------------------------------------
// Packet buffer free stack package
// Shared transaction types, request codes and controller/datapath interfaces.
// ----------------------------------------------------------------------------
package pbfs_pkg;

  localparam int IDX_W = 8;
  localparam int FUNC_W = 2;
  localparam int CFG_W = 9;

  localparam logic [FUNC_W-1:0] FN_GET = 2'd0;
  localparam logic [FUNC_W-1:0] FN_RETURN = 2'd1;
  localparam logic [FUNC_W-1:0] FN_RESET = 2'd2;

  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_UNINIT = 1'b1;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [IDX_W-1:0]  buffer_index;
  } req_t;

  typedef struct packed {
    logic             status;
    logic             granted;
    logic [IDX_W-1:0] granted_index;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_RESP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic res_status;
    logic res_granted;
    logic pop;
    logic push;
    logic fill_start;
    logic fill_step;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic uninit;
    logic empty;
    logic room;
    logic fill_done;
    logic out_free;
  } sts_t;

endpackage

// ----- design/pbfs_ctrl.sv -----
// ----------------------------------------------------------------------------
// Packet buffer free stack controller
// Decodes requests and sequences pops, pushes, the pool fill and the response.
// ----------------------------------------------------------------------------
module pbfs_ctrl
  import pbfs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [FUNC_W-1:0] func,
  input  sts_t              sts,
  output logic              in_stall,
  output cmd_t              cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (!sts.uninit && func == FN_RESET) begin
            state_next = ST_FILL;
          end else begin
            state_next = ST_RESP;
          end
        end
      end
      ST_FILL: begin
        if (sts.fill_done) begin
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    cmd = '0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          cmd.res_status = sts.uninit ? STATUS_UNINIT : STATUS_OK;
          cmd.res_granted = !sts.uninit && func == FN_GET && !sts.empty;
          cmd.pop = !sts.uninit && func == FN_GET && !sts.empty;
          cmd.push = !sts.uninit && func == FN_RETURN && sts.room;
          cmd.fill_start = !sts.uninit && func == FN_RESET;
        end
      end
      ST_FILL: begin
        cmd.fill_step = !sts.fill_done;
      end
      ST_RESP: begin
        cmd.load_out = sts.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

`ifndef SYNTHESIS
  // At most one stack operation is issued at a time.
  a_one_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.pop, cmd.push, cmd.fill_start, cmd.fill_step}))
    else $error("pbfs_ctrl: more than one stack operation issued");

  a_stall_when_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> in_stall)
    else $error("pbfs_ctrl: input open while busy");

  a_load_in_resp: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (state == ST_RESP))
    else $error("pbfs_ctrl: response loaded outside response state");
`endif

endmodule

// ----- design/pbfs_datapath.sv -----
// ----------------------------------------------------------------------------
// Packet buffer free stack datapath
// Pool size register, stack memory, free count, fill pointer and result
// register.
// ----------------------------------------------------------------------------
module pbfs_datapath
  import pbfs_pkg::*;
#(
  parameter int POOL_MAX = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  req_t             in_data,
  input  cmd_t             cmd,
  input  logic             out_stall,
  output sts_t             sts,
  output logic             out_valid,
  output rsp_t             out_data
);

  localparam int DEPTH = POOL_MAX + 1;
  localparam int CW = $clog2(POOL_MAX + 2);
  localparam int AW = $clog2(POOL_MAX + 1);
  localparam int SW = (CW > CFG_W) ? CW : CFG_W;
  localparam logic [SW-1:0] SIZE_LIMIT = SW'(POOL_MAX);
  localparam logic [CW-1:0] COUNT_LIMIT = CW'(POOL_MAX + 1);

  logic [CFG_W-1:0] pool_size;
  logic [CW-1:0]    free_count;
  logic [CW-1:0]    fill_ptr;
  logic [IDX_W-1:0] stack_mem [DEPTH];
  logic [IDX_W-1:0] rdata;
  logic             res_status;
  logic             res_granted;

  logic [SW-1:0]    size_wide;
  logic [CW-1:0]    eff_size;
  logic [CW-1:0]    count_dec;
  logic [AW-1:0]    waddr;
  logic [IDX_W-1:0] wdata;
  logic             we;

  // A configured size above POOL_MAX acts as POOL_MAX.
  always_comb begin
    size_wide = SW'(pool_size);
    eff_size = (size_wide > SIZE_LIMIT) ? CW'(SIZE_LIMIT) : CW'(size_wide);
    count_dec = free_count - CW'(1);
  end

  always_comb begin
    sts.uninit = (eff_size == '0);
    sts.empty = (free_count == '0);
    sts.room = (free_count <= eff_size);
    sts.fill_done = (fill_ptr == eff_size);
    sts.out_free = !out_valid || !out_stall;
  end

  always_comb begin
    we = cmd.push || cmd.fill_step;
    if (cmd.push) begin
      waddr = free_count[AW-1:0];
      wdata = in_data.buffer_index;
    end else begin
      waddr = fill_ptr[AW-1:0];
      wdata = IDX_W'(fill_ptr);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      stack_mem[waddr] <= wdata;
    end
    if (cmd.pop) begin
      rdata <= stack_mem[count_dec[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_size <= '0;
      free_count <= '0;
      fill_ptr <= '0;
    end else begin
      if (cfg_we) begin
        pool_size <= cfg_wdata;
      end
      if (cmd.pop) begin
        free_count <= count_dec;
      end else if (cmd.push) begin
        free_count <= free_count + CW'(1);
      end else if (cmd.fill_start) begin
        free_count <= '0;
      end else if (cmd.fill_step) begin
        free_count <= free_count + CW'(1);
      end
      if (cmd.fill_start) begin
        fill_ptr <= '0;
      end else if (cmd.fill_step) begin
        fill_ptr <= fill_ptr + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_status <= cmd.res_status;
      res_granted <= cmd.res_granted;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.status <= res_status;
      out_data.granted <= res_granted;
      out_data.granted_index <= res_granted ? rdata : '0;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    free_count <= COUNT_LIMIT)
    else $error("pbfs_datapath: free count beyond stack depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> free_count != '0)
    else $error("pbfs_datapath: pop from an empty stack");

  a_fill_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.fill_step |-> fill_ptr < eff_size)
    else $error("pbfs_datapath: fill pointer past pool size");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || !out_stall))
    else $error("pbfs_datapath: pending result overwritten");
`endif

endmodule

// ----- design/packet_buffer_free_stack_top.sv -----
// ----------------------------------------------------------------------------
// Packet buffer free stack
// LIFO free list of buffer indices with get, return and pool reset requests.
// ----------------------------------------------------------------------------
//  Channel  Signals                      Direction  Transaction
//  in       in_valid, in_stall, in_data  in         one request (func, index)
//  out      out_valid, out_stall, out_data  out     one response per request
//  cfg      cfg_we, cfg_wdata            in         pool size write
//
//  Get, return and unknown requests, and every request to an uninitialized
//  pool, are taken in the idle state, and the response register loads in
//  the response state, before the next request is taken.
//  A pool reset fills pool_size entries, with pool_size capped at POOL_MAX;
//  the fill writes one entry a cycle, then the response state follows.
//  Synchronous reset clears the pool size, free count and control state.
//  A stalled response holds the next transaction in its response state.
// ----------------------------------------------------------------------------
module packet_buffer_free_stack_top
  import pbfs_pkg::*;
#(
  parameter int POOL_MAX = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  req_t             in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output rsp_t             out_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  pbfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .func     (in_data.func),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  pbfs_datapath #(
    .POOL_MAX (POOL_MAX)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_stall (out_stall),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
